/* src/slo_pkg.sv */
// ----------------------------------------------------------------------------
// slo_pkg
// shared types and constants for the sight line occlusion clipper
// ----------------------------------------------------------------------------
`default_nettype none

package slo_pkg;

  localparam int CoordW  = 16;
  localparam int FixW    = 32;
  localparam int DivNumW = 52;
  localparam int DivDenW = 36;
  localparam int QuotW   = 40;
  localparam int DivCntW = 6;

  localparam logic KindQuery = 1'b0;
  localparam logic KindLine  = 1'b1;

  // classified word passed from front to back; for a query the heights hold
  // eye height, upper slope and lower slope
  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    logic                     one_sided;
    logic signed [FixW-1:0]   ha;
    logic signed [FixW-1:0]   hb;
    logic signed [FixW-1:0]   hc;
    logic signed [FixW-1:0]   hd;
  } item_t;

  typedef struct packed {
    logic sight_open;
    logic line_crossed;
  } result_t;

endpackage

`default_nettype wire

/* src/sight_line_occlusion_clipper.sv */
// a query word goes straight to its result; a line word runs the side tests
// and projections, then a fraction divide and, when crossed, up to two slope
// divides; the 40-step divider sets the pace
// one word is worked at a time; two words queue in front and two results behind
// reset clears the sight state, the queues and the blocked latch
// ----------------------------------------------------------------------------
// sight_line_occlusion_clipper
// line of sight test against a stream of walls with slope window clipping
// ----------------------------------------------------------------------------
`default_nettype none

module sight_line_occlusion_clipper (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               kind_i,
  input  wire logic signed [31:0] first_x_i,
  input  wire logic signed [31:0] first_y_i,
  input  wire logic signed [31:0] second_x_i,
  input  wire logic signed [31:0] second_y_i,
  input  wire logic               one_sided_i,
  input  wire logic signed [31:0] height_a_i,
  input  wire logic signed [31:0] height_b_i,
  input  wire logic signed [31:0] height_c_i,
  input  wire logic signed [31:0] height_d_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    sight_open_o,
  output logic                    line_crossed_o
);

  logic             fq_valid;
  logic             fq_pop;
  slo_pkg::item_t   fq_item;
  logic             res_valid;
  logic             res_ready;
  slo_pkg::result_t res;

  slo_pkg::result_t oq_q [2];
  logic             owr_q;
  logic             ord_q;
  logic [1:0]       ocnt_q;
  logic             o_wr;
  logic             o_rd;

  slo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .kind_i      (kind_i),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .one_sided_i (one_sided_i),
    .height_a_i  (height_a_i),
    .height_b_i  (height_b_i),
    .height_c_i  (height_c_i),
    .height_d_i  (height_d_i),
    .valid_o     (fq_valid),
    .item_o      (fq_item),
    .pop_i       (fq_pop)
  );

  slo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fq_valid),
    .item_i      (fq_item),
    .pop_o       (fq_pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result queue
  assign res_ready = !ocnt_q[1];
  assign o_wr      = res_valid && res_ready;
  assign o_rd      = pop && !empty;
  assign empty     = ocnt_q == 2'd0;
  assign sight_open_o   = oq_q[ord_q].sight_open;
  assign line_crossed_o = oq_q[ord_q].line_crossed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (o_wr) owr_q <= !owr_q;
      if (o_rd) ord_q <= !ord_q;
      if (o_wr && !o_rd) ocnt_q <= ocnt_q + 2'd1;
      else if (o_rd && !o_wr) ocnt_q <= ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_wr) oq_q[owr_q] <= res;
  end

endmodule

`default_nettype wire

/* src/slo_div.sv */
// ----------------------------------------------------------------------------
// slo_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module slo_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [slo_pkg::DivNumW-1:0]   num_i,
  input  wire logic [slo_pkg::DivDenW-1:0]   den_i,
  output logic                               done_o,
  output logic [slo_pkg::QuotW-1:0]          quot_o
);

  logic [slo_pkg::DivDenW-1:0] rem_q;
  logic [slo_pkg::DivDenW-1:0] den_q;
  logic [slo_pkg::QuotW-1:0]   sh_q;
  logic [slo_pkg::DivCntW-1:0] cnt_q;
  logic                        run_q;
  logic                        done_q;

  logic [slo_pkg::DivDenW:0] trial;
  logic [slo_pkg::DivDenW:0] diff;
  logic                      ge;

  assign trial = {rem_q, sh_q[slo_pkg::QuotW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == slo_pkg::DivCntW'(slo_pkg::QuotW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // high part of the numerator is below the divisor, so it seeds the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= slo_pkg::DivDenW'(num_i[slo_pkg::DivNumW-1:slo_pkg::QuotW]);
      sh_q  <= num_i[slo_pkg::QuotW-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[slo_pkg::DivDenW-1:0] : trial[slo_pkg::DivDenW-1:0];
      sh_q  <= {sh_q[slo_pkg::QuotW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

/* src/slo_front.sv */
// ----------------------------------------------------------------------------
// slo_front
// accepts words, snaps query positions, prepares eye height and slopes,
// and holds classified words in a two entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module slo_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic                kind_i,
  input  wire logic signed [31:0]  first_x_i,
  input  wire logic signed [31:0]  first_y_i,
  input  wire logic signed [31:0]  second_x_i,
  input  wire logic signed [31:0]  second_y_i,
  input  wire logic                one_sided_i,
  input  wire logic signed [31:0]  height_a_i,
  input  wire logic signed [31:0]  height_b_i,
  input  wire logic signed [31:0]  height_c_i,
  input  wire logic signed [31:0]  height_d_i,
  output logic                     valid_o,
  output slo_pkg::item_t           item_o,
  input  wire logic                pop_i
);

  slo_pkg::item_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  slo_pkg::item_t cls;
  logic signed [31:0] eye;
  logic               wr_en;
  logic               rd_en;

  assign eye = height_a_i + height_b_i - (height_b_i >>> 2);

  always_comb begin
    cls           = '0;
    cls.kind      = kind_i;
    cls.one_sided = one_sided_i;
    if (kind_i == slo_pkg::KindQuery) begin
      // snap to odd whole units
      cls.x1 = {first_x_i[31:17], 1'b1};
      cls.y1 = {first_y_i[31:17], 1'b1};
      cls.x2 = {second_x_i[31:17], 1'b1};
      cls.y2 = {second_y_i[31:17], 1'b1};
      cls.ha = eye;
      cls.hb = height_c_i + height_d_i - eye;
      cls.hc = height_c_i - eye;
      cls.hd = '0;
    end else begin
      cls.x1 = first_x_i[31:16];
      cls.y1 = first_y_i[31:16];
      cls.x2 = second_x_i[31:16];
      cls.y2 = second_y_i[31:16];
      cls.ha = height_a_i;
      cls.hb = height_b_i;
      cls.hc = height_c_i;
      cls.hd = height_d_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 2'd1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= cls;
  end

endmodule

`default_nettype wire

/* src/slo_back.sv */
// ----------------------------------------------------------------------------
// slo_back
// sight state and line sequencer: side tests and projections on one shared
// multiplier, fraction and slope divides on one shared divider
// ----------------------------------------------------------------------------
`default_nettype none

module slo_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire slo_pkg::item_t item_i,
  output logic                pop_o,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output slo_pkg::result_t    res_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_DEN  = 4'd3;
  localparam logic [3:0] S_FCHK = 4'd4;
  localparam logic [3:0] S_FDIV = 4'd5;
  localparam logic [3:0] S_CLIP = 4'd6;
  localparam logic [3:0] S_LO   = 4'd7;
  localparam logic [3:0] S_LOW  = 4'd8;
  localparam logic [3:0] S_HI   = 4'd9;
  localparam logic [3:0] S_HIW  = 4'd10;
  localparam logic [3:0] S_CHK  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic signed [31:0] FracMin  = 32'sd4;
  localparam logic signed [31:0] FracOne  = 32'sh10000;
  localparam logic [40:0]        SlopeMax = 41'h7fffff;
  localparam logic [40:0]        SlopeMin = 41'h800000;

  function automatic logic signed [16:0] sub16(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    sub16 = {a[15], a} - {b[15], b};
  endfunction

  // quotient times 256, clamped to the signed 32-bit range
  function automatic logic signed [31:0] slope_sat(input logic neg,
                                                   input logic [39:0] mag);
    logic [40:0] m;
    logic [31:0] sh;
    m  = {1'b0, mag};
    sh = {mag[23:0], 8'd0};
    if (!neg) slope_sat = (m > SlopeMax) ? 32'sh7fffffff : sh;
    else      slope_sat = (m > SlopeMin) ? 32'sh80000000 : -sh;
  endfunction

  logic [3:0]         st_q;
  slo_pkg::item_t     cur_q;
  logic signed [15:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [31:0] eye_q, up_q, lo_q;
  logic               blk_q;
  logic               crossed_q;
  logic [2:0]         cnt_q;
  logic signed [33:0] pr_q [8];
  logic signed [34:0] a_q, b_q;
  logic signed [35:0] den_q;
  logic               side_ne_q;
  logic               neg_q;
  logic signed [31:0] frac_q;
  logic signed [31:0] top_q, bot_q;

  logic signed [16:0] op_a, op_b;
  logic signed [16:0] ndx, ndy, d1x, d1y, d2x, d2y, nx, ny, fx, fy;
  logic [35:0]        abs_a, abs_den;
  logic [31:0]        frac;
  logic               div_start, div_done;
  logic [51:0]        div_num;
  logic [35:0]        div_den;
  logic [39:0]        div_quot;
  logic signed [31:0] edge_sel;
  logic signed [32:0] ediff;
  logic signed [38:0] dsc;
  logic [38:0]        dabs;
  logic signed [31:0] slope;
  logic signed [31:0] top, bot;

  assign ndx = sub16(ex_q, sx_q);
  assign ndy = sub16(ey_q, sy_q);
  assign d2x = sub16(cur_q.x2, sx_q);
  assign d2y = sub16(cur_q.y2, sy_q);
  assign d1x = sub16(cur_q.x1, sx_q);
  assign d1y = sub16(cur_q.y1, sy_q);
  assign nx  = sub16(cur_q.y1, cur_q.y2);
  assign ny  = sub16(cur_q.x2, cur_q.x1);
  assign fx  = sub16(ex_q, cur_q.x1);
  assign fy  = sub16(ey_q, cur_q.y1);

  always_comb begin
    case (cnt_q)
      3'd0:    begin op_a = ndy; op_b = d2x; end
      3'd1:    begin op_a = d2y; op_b = ndx; end
      3'd2:    begin op_a = ndy; op_b = d1x; end
      3'd3:    begin op_a = d1y; op_b = ndx; end
      3'd4:    begin op_a = nx;  op_b = d1x; end
      3'd5:    begin op_a = ny;  op_b = d1y; end
      3'd6:    begin op_a = nx;  op_b = fx;  end
      default: begin op_a = ny;  op_b = fy;  end
    endcase
  end

  assign abs_a   = a_q[34] ? -{a_q[34], a_q} : {a_q[34], a_q};
  assign abs_den = den_q[35] ? -den_q : den_q;
  assign frac    = neg_q ? -div_quot[31:0] : div_quot[31:0];

  assign top = (cur_q.hb < cur_q.hd) ? cur_q.hb : cur_q.hd;
  assign bot = (cur_q.ha > cur_q.hc) ? cur_q.ha : cur_q.hc;

  // slope numerator: (edge - eye) * 64
  assign edge_sel = (st_q == S_LO) ? bot_q : top_q;
  assign ediff    = {edge_sel[31], edge_sel} - {eye_q[31], eye_q};
  assign dsc      = {ediff, 6'd0};
  assign dabs     = dsc[38] ? -dsc : dsc;
  assign slope    = slope_sat(neg_q, div_quot);

  always_comb begin
    div_start = 1'b0;
    div_num   = {abs_a, 16'd0};
    div_den   = abs_den;
    if (st_q == S_FCHK) begin
      div_start = side_ne_q && ((abs_a >> 14) < abs_den);
    end else if (st_q == S_LO || st_q == S_HI) begin
      div_num   = {13'd0, dabs};
      div_den   = {21'd0, frac_q[16:2]};
      div_start = (st_q == S_LO) ? (cur_q.ha != cur_q.hc) : (cur_q.hb != cur_q.hd);
    end
  end

  slo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign pop_o       = (st_q == S_IDLE) && valid_i;
  assign res_valid_o = st_q == S_OUT;
  assign res_o.sight_open   = !blk_q;
  assign res_o.line_crossed = crossed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      sx_q      <= '0;
      sy_q      <= '0;
      ex_q      <= '0;
      ey_q      <= '0;
      eye_q     <= '0;
      up_q      <= '0;
      lo_q      <= '0;
      blk_q     <= 1'b0;
      crossed_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (valid_i) begin
            crossed_q <= 1'b0;
            cnt_q     <= '0;
            if (item_i.kind == slo_pkg::KindQuery) begin
              sx_q  <= item_i.x1;
              sy_q  <= item_i.y1;
              ex_q  <= item_i.x2;
              ey_q  <= item_i.y2;
              eye_q <= item_i.ha;
              up_q  <= item_i.hb;
              lo_q  <= item_i.hc;
              blk_q <= 1'b0;
              st_q  <= S_OUT;
            end else begin
              st_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) st_q <= S_SUM;
        end
        S_SUM:  st_q <= S_DEN;
        S_DEN:  st_q <= S_FCHK;
        S_FCHK: st_q <= div_start ? S_FDIV : S_OUT;
        S_FDIV: begin
          if (div_done) begin
            crossed_q <= ($signed(frac) >= FracMin) && ($signed(frac) <= FracOne);
            st_q <= (($signed(frac) >= FracMin) && ($signed(frac) <= FracOne) && !blk_q)
                    ? S_CLIP : S_OUT;
          end
        end
        S_CLIP: begin
          if (cur_q.one_sided) begin
            blk_q <= 1'b1;
            st_q  <= S_OUT;
          end else if (cur_q.ha == cur_q.hc && cur_q.hb == cur_q.hd) begin
            st_q <= S_OUT;
          end else if (bot >= top) begin
            blk_q <= 1'b1;
            st_q  <= S_OUT;
          end else begin
            st_q <= S_LO;
          end
        end
        S_LO: st_q <= div_start ? S_LOW : S_HI;
        S_LOW: begin
          if (div_done) begin
            if (slope > lo_q) lo_q <= slope;
            st_q <= S_HI;
          end
        end
        S_HI: st_q <= div_start ? S_HIW : S_CHK;
        S_HIW: begin
          if (div_done) begin
            if (slope < up_q) up_q <= slope;
            st_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (up_q <= lo_q) blk_q <= 1'b1;
          st_q <= S_OUT;
        end
        S_OUT: begin
          if (res_ready_i) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
    if (st_q == S_MUL) pr_q[cnt_q] <= op_a * op_b;
    if (st_q == S_SUM) begin
      a_q       <= {pr_q[4][33], pr_q[4]} + {pr_q[5][33], pr_q[5]};
      b_q       <= {pr_q[6][33], pr_q[6]} + {pr_q[7][33], pr_q[7]};
      side_ne_q <= (pr_q[0] < pr_q[1]) != (pr_q[2] < pr_q[3]);
    end
    if (st_q == S_DEN) den_q <= {a_q[34], a_q} + {b_q[34], b_q};
    if (st_q == S_FCHK) neg_q <= a_q[34] ^ den_q[35];
    if (st_q == S_FDIV && div_done) frac_q <= frac;
    if (st_q == S_CLIP) begin
      top_q <= top;
      bot_q <= bot;
    end
    if (st_q == S_LO || st_q == S_HI) neg_q <= dsc[38];
  end

endmodule

`default_nettype wire
